### src/frame_allocate_oldest_evict_macros.svh
// assertion macros for the frame allocator
// used by the datapath and the controller, no other dependencies
`ifndef FRAME_ALLOCATE_OLDEST_EVICT_MACROS_SVH
`define FRAME_ALLOCATE_OLDEST_EVICT_MACROS_SVH
`ifndef SYNTHESIS
`define FAO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define FAO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FAO_ASSERT(label, clk, rst_n, prop)
`define FAO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### src/fao_pkg.sv
// shared constants and controller/datapath interface types
// no dependencies
package fao_pkg;

    localparam int FRAMES     = 256;
    localparam int TAG_BITS   = 32;
    localparam int STAMP_BITS = 32;

    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);

    localparam int TAG_IN_W    = 32;
    localparam int STAMP_IN_W  = 32;
    localparam int IDX_OUT_W   = 8;
    localparam int TAG_OUT_W   = 32;

    typedef struct packed {
        logic accept;
        logic scan;
        logic tag_rd;
        logic place;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

### src/frame_allocate_oldest_evict.sv
// top level of the frame allocator with oldest-stamp eviction
// depends on fao_pkg, fao_ctrl and fao_dp
//
// channel  direction  handshake             word
// in       input      in_valid / in_stall   frame_tag, stamp
// out      output     out_valid / out_stall frame_index, evicted, evicted_tag
//
// while a free frame remains a word is accepted, then placed
// once all frames are taken a word is accepted, then the stamp
// ram is read one entry per cycle to find the minimum, then the tag is read
// no clearing pass after reset, frames fill in order behind a fill count
// a waiting result holds placement of the next word, not its acceptance
module frame_allocate_oldest_evict
    import fao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [TAG_IN_W-1:0]   frame_tag,
    input  logic [STAMP_IN_W-1:0] stamp,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_OUT_W-1:0]  frame_index,
    output logic                  evicted,
    output logic [TAG_OUT_W-1:0]  evicted_tag
);

    dp_cmd_t    cmd;
    dp_status_t status;

    fao_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .status  (status),
        .cmd     (cmd)
    );

    fao_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .frame_tag  (frame_tag),
        .stamp      (stamp),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .frame_index(frame_index),
        .evicted    (evicted),
        .evicted_tag(evicted_tag)
    );

endmodule

### src/fao_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module fao_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/fao_dp.sv
// datapath: fill count, stamp and tag rams, minimum-stamp scan, result register
// depends on fao_pkg, fao_ram and the macros header
`include "frame_allocate_oldest_evict_macros.svh"

module fao_dp
    import fao_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [TAG_IN_W-1:0]   frame_tag,
    input  logic [STAMP_IN_W-1:0] stamp,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [IDX_OUT_W-1:0]  frame_index,
    output logic                  evicted,
    output logic [TAG_OUT_W-1:0]  evicted_tag
);

    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [FIDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                  pend_reg;
    logic [FIDX_W-1:0]     pend_idx_reg;
    logic [FIDX_W-1:0]     slot_reg, slot_next;
    logic [STAMP_BITS-1:0] best_reg, best_next;
    logic                  full_reg;
    logic [TAG_BITS-1:0]   tag_in_reg;
    logic [STAMP_BITS-1:0] stamp_in_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [IDX_OUT_W-1:0]  frame_index_reg;
    logic                  evicted_reg;
    logic [TAG_OUT_W-1:0]  evicted_tag_reg;

    logic [STAMP_BITS-1:0] st_rdata;
    logic [TAG_BITS-1:0]   tag_rdata;
    logic                  take;

    fao_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(FRAMES)
    ) u_stamp_ram (
        .clk    (clk),
        .wr_en  (cmd.place),
        .wr_addr(slot_reg),
        .wr_data(stamp_in_reg),
        .rd_en  (cmd.scan),
        .rd_addr(scan_cnt_reg),
        .rd_data(st_rdata)
    );

    fao_ram #(
        .WIDTH(TAG_BITS),
        .DEPTH(FRAMES)
    ) u_tag_ram (
        .clk    (clk),
        .wr_en  (cmd.place),
        .wr_addr(slot_reg),
        .wr_data(tag_in_reg),
        .rd_en  (cmd.tag_rd),
        .rd_addr(slot_reg),
        .rd_data(tag_rdata)
    );

    assign status.full      = (cnt_reg == CNT_W'(FRAMES));
    assign status.scan_last = (scan_cnt_reg == FIDX_W'(FRAMES - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // first entry seeds the minimum, strict less keeps the lowest index on ties
    assign take = (pend_idx_reg == '0) || (st_rdata < best_reg);

    always_comb
    begin
        cnt_next       = cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        slot_next      = slot_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        if (cmd.accept)
        begin
            scan_cnt_next = '0;
            slot_next     = cnt_reg[FIDX_W-1:0];
        end
        if (cmd.scan)
        begin
            scan_cnt_next = scan_cnt_reg + FIDX_W'(1);
        end
        if (pend_reg && take)
        begin
            slot_next = pend_idx_reg;
            best_next = st_rdata;
        end
        if (cmd.place && !full_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.place)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            full_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= cmd.scan;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                full_reg <= status.full;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg <= scan_cnt_next;
        pend_idx_reg <= scan_cnt_reg;
        slot_reg     <= slot_next;
        best_reg     <= best_next;
        if (cmd.accept)
        begin
            tag_in_reg   <= TAG_BITS'(frame_tag);
            stamp_in_reg <= STAMP_BITS'(stamp);
        end
        if (cmd.place)
        begin
            frame_index_reg <= IDX_OUT_W'(slot_reg);
            evicted_reg     <= full_reg;
            evicted_tag_reg <= full_reg ? TAG_OUT_W'(tag_rdata) : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_index_reg;
    assign evicted     = evicted_reg;
    assign evicted_tag = evicted_tag_reg;

    `FAO_ASSERT(a_cnt_range, clk, rst_n, cnt_reg <= CNT_W'(FRAMES))
    `FAO_ASSERT(a_place_free, clk, rst_n, !cmd.place || status.out_free)
    `FAO_ASSERT(a_evict_full, clk, rst_n, !(out_valid_reg && evicted_reg) || status.full)
    `FAO_ASSERT_NEXT(a_scan_pend, clk, rst_n, cmd.scan, pend_reg)

endmodule

### src/fao_ctrl.sv
// controller: sequences accept, stamp scan, tag read and placement
// depends on fao_pkg and the macros header
`include "frame_allocate_oldest_evict_macros.svh"

module fao_ctrl
    import fao_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_TAG,
        S_PLACE
    } state_t;

    state_t state_reg, state_next;
    logic   in_stall_reg, in_stall_next;

    always_comb
    begin
        cmd           = '0;
        state_next    = state_reg;
        in_stall_next = in_stall_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.accept    = 1'b1;
                    in_stall_next = 1'b1;
                    state_next    = status.full ? S_SCAN : S_PLACE;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_TAG;
            end
            S_TAG:
            begin
                cmd.tag_rd = 1'b1;
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (status.out_free)
                begin
                    cmd.place     = 1'b1;
                    in_stall_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= in_stall_next;
        end
    end

    assign in_stall = in_stall_reg;

    `FAO_ASSERT(a_stall_idle, clk, rst_n, (state_reg == S_IDLE) == !in_stall_reg)
    `FAO_ASSERT_NEXT(a_accept_stall, clk, rst_n, cmd.accept, in_stall_reg)
    `FAO_ASSERT_NEXT(a_tag_place, clk, rst_n, cmd.tag_rd, state_reg == S_PLACE)

endmodule

### sim/tb_frame_allocate_oldest_evict.sv
// testbench for frame_allocate_oldest_evict: directed and random placement requests,
// checked against an in-bench frame table with oldest-stamp eviction
// depends on fao_pkg and the frame_allocate_oldest_evict rtl
module tb_frame_allocate_oldest_evict
    import fao_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [TAG_IN_W-1:0]   tag;
        logic [STAMP_IN_W-1:0] stamp;
    } request_t;

    typedef struct {
        logic [IDX_OUT_W-1:0] index;
        logic                 gone;
        logic [TAG_OUT_W-1:0] gone_tag;
    } placement_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TAG_IN_W-1:0]   frame_tag;
    logic [STAMP_IN_W-1:0] stamp;
    logic                  out_valid;
    logic                  out_stall;
    logic [IDX_OUT_W-1:0]  frame_index;
    logic                  evicted;
    logic [TAG_OUT_W-1:0]  evicted_tag;

    request_t   requests_waiting[$];
    placement_t placements_due[$];

    logic                  frame_busy[FRAMES];
    logic [STAMP_BITS-1:0] frame_stamp[FRAMES];
    logic [TAG_BITS-1:0]   frame_owner[FRAMES];

    int          errors;
    int          results_seen;
    logic [31:0] now_stamp;

    int send_gap;
    int send_calm;
    int recv_gap;
    int recv_calm;
    int hold_left;
    int holds_done;

    frame_allocate_oldest_evict dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .frame_tag   (frame_tag),
        .stamp       (stamp),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_index (frame_index),
        .evicted     (evicted),
        .evicted_tag (evicted_tag)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // lowest free frame, else the oldest stamp with the lowest index on a tie
    function automatic void place_frame(logic [TAG_IN_W-1:0] tag, logic [STAMP_IN_W-1:0] st);
        int               slot;
        bit               found;
        placement_t       p;
        logic [TAG_BITS-1:0] old_tag;
        slot = 0;
        found = 1'b0;
        old_tag = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found && !frame_busy[i])
            begin
                slot = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            for (int i = 1; i < FRAMES; i++)
            begin
                if (frame_stamp[i] < frame_stamp[slot])
                    slot = i;
            end
            old_tag = frame_owner[slot];
        end
        frame_busy[slot] = 1'b1;
        frame_owner[slot] = TAG_BITS'(tag);
        frame_stamp[slot] = STAMP_BITS'(st);
        p.index = IDX_OUT_W'(slot);
        p.gone = !found;
        p.gone_tag = TAG_OUT_W'(old_tag);
        placements_due.push_back(p);
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 80);
    endfunction

    // mostly a rising time base with repeats, plus extremes and full-range values
    function automatic logic [31:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        now_stamp = now_stamp + $urandom_range(0, 3);
        if (r < 55)
            return now_stamp;
        else if (r < 75)
            return $urandom;
        else if (r < 88)
            return $urandom_range(0, 3);
        else
            return 32'hffff_fff0 + $urandom_range(0, 15);
    endfunction

    function automatic logic [31:0] pick_tag();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return $urandom;
    endfunction

    task automatic queue_word(logic [31:0] tag, logic [31:0] st);
        request_t q;
        q.tag = tag;
        q.stamp = st;
        requests_waiting.push_back(q);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
            queue_word(pick_tag(), pick_stamp());
    endtask

    task automatic wait_drained();
        while (requests_waiting.size() != 0 || in_valid || placements_due.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            frame_tag <= '0;
            stamp <= '0;
            send_gap <= 0;
            send_calm <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                place_frame(frame_tag, stamp);
            if (send_calm > 0)
                send_calm <= send_calm - 1;
            else if ($urandom_range(0, 299) == 0)
                send_calm <= $urandom_range(100, 400);
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (requests_waiting.size() > 0)
            begin
                nxt = requests_waiting.pop_front();
                in_valid <= 1'b1;
                frame_tag <= nxt.tag;
                stamp <= nxt.stamp;
                send_gap <= (send_calm > 0) ? 0 : idle_len();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // random stalls, plus two long hold-offs that back the block up to its input
    always @(posedge clk or negedge rst_n)
    begin : recv
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            recv_calm <= 0;
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end
        else if ((holds_done == 0 && results_seen >= 100) ||
                 (holds_done == 1 && results_seen >= 600))
        begin
            holds_done <= holds_done + 1;
            hold_left <= 1200;
            out_stall <= 1'b1;
        end
        else
        begin
            if (recv_calm > 0)
                recv_calm <= recv_calm - 1;
            else if ($urandom_range(0, 299) == 0)
                recv_calm <= $urandom_range(100, 400);
            if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else if (recv_calm == 0 && $urandom_range(0, 3) == 0)
            begin
                recv_gap <= idle_len();
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        placement_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (placements_due.size() == 0)
            begin
                $error("word out with no request pending: frame_index %0d", frame_index);
                errors++;
            end
            else
            begin
                want = placements_due.pop_front();
                if (frame_index !== want.index)
                begin
                    $error("frame_index: expected %0d, got %0d", want.index, frame_index);
                    errors++;
                end
                if (evicted !== want.gone)
                begin
                    $error("evicted: expected %0b, got %0b", want.gone, evicted);
                    errors++;
                end
                if (evicted_tag !== want.gone_tag)
                begin
                    $error("evicted_tag: expected %h, got %h", want.gone_tag, evicted_tag);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        results_seen = 0;
        now_stamp = 32'h0000_1000;
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_busy[i] = 1'b0;
            frame_stamp[i] = '0;
            frame_owner[i] = '0;
        end
        rst_n = 1'b0;

        // field extremes and equal stamps, evicted later in index order
        queue_word(32'h0000_0000, 32'h0000_0000);
        queue_word(32'hffff_ffff, 32'hffff_ffff);
        queue_word(32'haaaa_aaaa, 32'h0000_0000);
        queue_word(32'h5555_5555, 32'h5555_5555);
        queue_word(32'h0000_0001, 32'haaaa_aaaa);
        queue_word(32'h8000_0000, 32'h8000_0000);
        queue_word(32'h7fff_ffff, 32'h7fff_ffff);
        queue_word(32'hffff_ffff, 32'h0000_0001);
        queue_word(32'h0000_0000, 32'hffff_fffe);
        queue_word(32'h1234_5678, 32'h0000_0000);
        queue_random(310);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait_drained();
        queue_random(780);
        wait_drained();
        repeat (300) @(negedge clk);

        if (placements_due.size() != 0)
        begin
            $error("%0d words never came out", placements_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
